@@ hw/rtl/lcc_pkg.sv @@
// ----------------------------------------------------------------------------
// lcc_pkg: shared types and constants of the card number checker
// Field widths, engine sizing, queue depth, card kinds, the state type, the
// result word and the power-of-ten helper for the digit threshold table.
// ----------------------------------------------------------------------------
package lcc_pkg;

  // payload widths
  localparam int CARD_W  = 64;
  localparam int COUNT_W = 5;
  localparam int KIND_W  = 2;

  // a 64-bit value has at most 20 decimal digits
  localparam int NUM_POS = 20;
  localparam int POS_W   = $clog2(NUM_POS);

  // thresholds reach 9 * 10^19, which needs 67 bits
  localparam int THR_W = CARD_W + 4;

  // most digits checked by default
  localparam int LCC_MAX_DIGITS = 19;

  // input queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  // card kinds
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PFX3X = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PFX5X = 2'd2;
  localparam logic [KIND_W-1:0] KIND_PFX4  = 2'd3;

  // digit engine states
  typedef enum logic [1:0] {
    LCC_IDLE,
    LCC_RUN,
    LCC_FINISH
  } lcc_state_t;

  // result word as kept in the output register
  typedef struct packed {
    logic                 luhn_ok;
    logic [KIND_W-1:0]    card_kind;
    logic [COUNT_W-1:0]   digit_count;
    logic                 accepted;
  } lcc_result_t;

  // 10^k, evaluated at elaboration only
  function automatic logic [THR_W-1:0] lcc_pow10(input int k);
    logic [THR_W-1:0] p;
    p = THR_W'(1);
    for (int i = 0; i < k; i++) begin
      p = p * THR_W'(10);
    end
    return p;
  endfunction

endpackage

@@ hw/rtl/lcc_if.sv @@
// ----------------------------------------------------------------------------
// lcc_if: handshake channels of the card number checker
// One channel carries card numbers in, the other carries check results out.
// ----------------------------------------------------------------------------
interface lcc_card_if;
  import lcc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CARD_W-1:0] card_num;

  modport source (output valid, output card_num, input ready);
  modport sink   (input valid, input card_num, output ready);
endinterface

interface lcc_result_if;
  import lcc_pkg::*;

  logic               valid;
  logic               ready;
  logic               luhn_ok;
  logic [KIND_W-1:0]  card_kind;
  logic [COUNT_W-1:0] digit_count;
  logic               accepted;

  modport source (output valid, output luhn_ok, output card_kind,
                  output digit_count, output accepted, input ready);
  modport sink   (input valid, input luhn_ok, input card_kind,
                  input digit_count, input accepted, output ready);
endinterface

@@ hw/rtl/lcc_queue.sv @@
// ----------------------------------------------------------------------------
// lcc_queue: short word queue between the front and the digit engine
// Takes card numbers from the input channel and holds them until the
// back end pops them, so either side can stall on its own.
// ----------------------------------------------------------------------------
module lcc_queue #(
  parameter int DATA_W = lcc_pkg::CARD_W,
  parameter int DEPTH  = lcc_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);
  import lcc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // store an incoming word
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

@@ hw/rtl/lcc_back.sv @@
// ----------------------------------------------------------------------------
// lcc_back: digit engine and result register
// Walks the decimal positions from 10^19 down to 10^0, one per cycle,
// finding each digit by comparing against its nine multiples. Forms the
// Luhn sum mod ten, the digit count and the leading pair, then classifies.
// ----------------------------------------------------------------------------
module lcc_back #(
  parameter int MAX_DIGITS = lcc_pkg::LCC_MAX_DIGITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  output logic                      q_pop,
  input  logic [lcc_pkg::CARD_W-1:0] q_data,
  lcc_result_if.source              result
);
  import lcc_pkg::*;

  // digit thresholds m * 10^k, fixed at elaboration
  logic [THR_W-1:0] thr [NUM_POS][10];

  for (genvar k = 0; k < NUM_POS; k++) begin : g_pos
    for (genvar m = 0; m < 10; m++) begin : g_mul
      localparam logic [THR_W-1:0] THR_VAL = lcc_pow10(k) * THR_W'(m);
      assign thr[k][m] = THR_VAL;
    end
  end

  lcc_state_t         state;
  lcc_state_t         state_next;
  logic [POS_W-1:0]   pos;
  logic [CARD_W-1:0]  rest;
  logic [3:0]         msum;
  logic [COUNT_W-1:0] count;
  logic [3:0]         lead_hi;
  logic [3:0]         lead_lo;
  lcc_result_t        res_word;

  logic               out_free;
  logic               load;
  logic               step;
  logic               emit;

  logic [THR_W-1:0]   rest_ext;
  logic [3:0]         digit;
  logic [THR_W-1:0]   sub_val;
  logic [4:0]         dbl;
  logic [4:0]         add_val;
  logic [4:0]         sum_tmp;
  logic [3:0]         msum_next;
  logic               too_long;
  logic [KIND_W-1:0]  kind;
  logic               luhn;

  assign out_free = !result.valid || result.ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      LCC_IDLE: begin
        if (q_valid) state_next = LCC_RUN;
      end
      LCC_RUN: begin
        if (pos == '0) state_next = LCC_FINISH;
      end
      LCC_FINISH: begin
        if (out_free) state_next = q_valid ? LCC_RUN : LCC_IDLE;
      end
      default: state_next = LCC_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    load = 1'b0;
    step = 1'b0;
    emit = 1'b0;
    case (state)
      LCC_IDLE: begin
        load = q_valid;
      end
      LCC_RUN: begin
        step = 1'b1;
      end
      LCC_FINISH: begin
        emit = out_free;
        load = out_free && q_valid;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  assign q_pop = load;

  // pick the digit at this position: largest m with m * 10^pos <= rest
  always_comb begin
    rest_ext = {{(THR_W - CARD_W){1'b0}}, rest};
    digit    = 4'd0;
    for (int m = 1; m < 10; m++) begin
      if (rest_ext >= thr[pos][m]) digit = 4'(m);
    end
    sub_val = thr[pos][digit];
  end

  // Luhn term: odd positions are doubled and folded back to one digit
  always_comb begin
    dbl       = {digit, 1'b0};
    add_val   = pos[0] ? ((dbl > 5'd9) ? dbl - 5'd9 : dbl) : {1'b0, digit};
    sum_tmp   = {1'b0, msum} + add_val;
    msum_next = (sum_tmp >= 5'd10) ? 4'(sum_tmp - 5'd10) : sum_tmp[3:0];
  end

  // classify from the leading pair and the length
  always_comb begin
    too_long = (count > COUNT_W'(MAX_DIGITS));
    kind     = KIND_NONE;
    if (lead_hi == 4'd3 && (lead_lo == 4'd4 || lead_lo == 4'd7) &&
        count == 5'd15) begin
      kind = KIND_PFX3X;
    end else if (lead_hi == 4'd5 && lead_lo >= 4'd1 && lead_lo <= 4'd5 &&
                 count == 5'd16) begin
      kind = KIND_PFX5X;
    end else if (lead_hi == 4'd4 && (count == 5'd13 || count == 5'd16)) begin
      kind = KIND_PFX4;
    end
    luhn = (msum == 4'd0);
    if (too_long) begin
      luhn = 1'b0;
      kind = KIND_NONE;
    end
    res_word.luhn_ok     = luhn;
    res_word.card_kind   = kind;
    res_word.digit_count = count;
    res_word.accepted    = luhn && (kind != KIND_NONE);
  end

  // hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LCC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // load a new word, or advance one position
  always_ff @(posedge clk) begin
    if (load) begin
      rest    <= q_data;
      pos     <= POS_W'(NUM_POS - 1);
      msum    <= 4'd0;
      count   <= '0;
      lead_hi <= 4'd0;
      lead_lo <= 4'd0;
    end else if (step) begin
      rest <= rest - sub_val[CARD_W-1:0];
      msum <= msum_next;
      if (pos != '0) pos <= pos - POS_W'(1);
      // first nonzero digit fixes the length and the leading digit
      if (count == '0 && digit != 4'd0) begin
        count   <= COUNT_W'(pos) + COUNT_W'(1);
        lead_hi <= digit;
      end
      // the position right after it gives the second leading digit
      if (count != '0 && COUNT_W'(pos) + COUNT_W'(2) == count) begin
        lead_lo <= digit;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.luhn_ok     <= res_word.luhn_ok;
      result.card_kind   <= res_word.card_kind;
      result.digit_count <= res_word.digit_count;
      result.accepted    <= res_word.accepted;
    end
  end

endmodule

@@ hw/rtl/card_number_luhn_classifier_unit.sv @@
// Flow: an accepted card word waits in the queue; the digit engine then
//   walks all 20 decimal positions of the 64-bit value, one per cycle, and
//   a finish state writes the result word once the output side is free.
//   The engine takes the next word only in its finish state or when idle.
// Reset: synchronous; empties the queue, idles the engine and drops any
//   pending result. No clearing pass.
// ----------------------------------------------------------------------------
// card_number_luhn_classifier_unit: card number Luhn check and classifier
// A front queue takes card words; the back digit engine forms the digit
// count, Luhn mod-10 check and card kind and hands out one result word each.
// ----------------------------------------------------------------------------
module card_number_luhn_classifier_unit #(
  parameter int MAX_DIGITS = lcc_pkg::LCC_MAX_DIGITS
) (
  input  logic          clk,
  input  logic          rst,
  lcc_card_if.sink      card,
  lcc_result_if.source  result
);
  import lcc_pkg::*;

  logic              q_valid;
  logic              q_pop;
  logic [CARD_W-1:0] q_data;

  // front: queue incoming card words
  lcc_queue #(
    .DATA_W (CARD_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (card.valid),
    .push_ready (card.ready),
    .push_data  (card.card_num),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop),
    .pop_data   (q_data)
  );

  // back: digit engine and result register
  lcc_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_data  (q_data),
    .result  (result)
  );

`ifndef SYNTHESIS
  // a recognized kind only comes with its own lengths
  a_kind_len: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.card_kind != KIND_NONE |->
      result.digit_count == 5'd13 || result.digit_count == 5'd15 ||
      result.digit_count == 5'd16)
    else $error("card kind with impossible length");

  // accept only on a passing check of a known kind
  a_accept: assert property (@(posedge clk) disable iff (rst)
    result.valid |->
      result.accepted == (result.luhn_ok && result.card_kind != KIND_NONE))
    else $error("accepted flag inconsistent");

  // overlong numbers never pass the check
  a_too_long: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.digit_count > 5'(MAX_DIGITS) |->
      !result.luhn_ok && result.card_kind == KIND_NONE)
    else $error("overlong number not rejected");

  // a 64-bit value has at most 20 digits
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.digit_count <= 5'(NUM_POS))
    else $error("digit count out of range");
`endif

endmodule
